// ----- hdl/ibid_pkg.sv -----
// ----------------------------------------------------------------------------
// ibid_pkg: shared types and constants of the IMSI identity decoder
// Beat and result payload structs, accumulator state, the country table
// for three-digit network codes.
// ----------------------------------------------------------------------------
package ibid_pkg;

    localparam int MAX_PACKED_BYTES = 8;

    localparam logic [3:0] IMSI_TYPE_EVEN   = 4'd1;
    localparam logic [3:0] IMSI_TYPE_ODD    = 4'd9;
    localparam logic [3:0] NIBBLE_FILLER    = 4'hF;
    localparam logic [3:0] MAX_DIGIT_VALUE  = 4'd9;
    localparam logic [4:0] MIN_VALID_DIGITS = 5'd6;
    localparam logic [4:0] MAX_DIGITS       = 5'd16;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic        ok;
        logic [4:0]  digit_count;
        logic [63:0] packed_key;
        logic [53:0] imsi_number;
        logic [9:0]  country_code;
        logic [9:0]  network_code;
        logic        wide_network_code;
        logic [36:0] subscriber_number;
        logic        valid_res;
    } t_result;

    typedef struct packed {
        logic [3:0]  byte_index;
        logic        latched_mode;
        logic        odd_flag;
        logic        type_error;
        logic [4:0]  digits_seen;
        logic [63:0] packed_digits;
        logic [53:0] decimal_total;
        logic [9:0]  country_acc;
        logic [9:0]  network_acc;
        logic [36:0] subscriber_acc;
        logic        three_digit_flag;
        logic        bad_digit;
    } t_acc_state;

    // Countries whose network codes carry three digits
    function automatic logic wide_country(input logic [9:0] code);
        logic hit;
        case (code)
            10'd302, 10'd310, 10'd311, 10'd312, 10'd313, 10'd314, 10'd315,
            10'd316, 10'd338, 10'd342, 10'd344, 10'd346, 10'd348, 10'd352,
            10'd358, 10'd360, 10'd364, 10'd365, 10'd722, 10'd732,
            10'd890: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// ----- hdl/imsi_bcd_identity_decoder.sv -----
// ----------------------------------------------------------------------------
// imsi_bcd_identity_decoder: IMSI identity element decoder
// Decodes 24.008 mobile-identity or TBCD octets into IMSI digits and fields.
// ----------------------------------------------------------------------------
// Result: a final beat is held in the input register, and its result is loaded
// into the result register once that register is empty or not stalled.
// Throughput: one octet beat per cycle, set by the single-pass accumulator; a
// final beat waits only while the result register is full and stalled.
// Reset: synchronous, active low; clears both stage valids and the
// accumulator, so the next beat starts a new element.
module imsi_bcd_identity_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ibid_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ibid_pkg::t_result   o_out_data
);

    logic                 r_in_valid;
    ibid_pkg::t_in_beat   r_in;
    logic                 r_out_valid;
    ibid_pkg::t_result    r_out;

    logic                 out_load_ok;
    logic                 in_consume;
    logic                 in_ready;
    ibid_pkg::t_acc_state acc_next;
    ibid_pkg::t_result    result;

    assign out_load_ok = !r_out_valid || !i_out_stall;
    // a final beat waits for room in the result register; others drain freely
    assign in_consume  = r_in_valid && (!r_in.last || out_load_ok);
    assign in_ready    = !r_in_valid || in_consume;

    ibid_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (in_consume),
        .i_beat    (r_in),
        .o_next    (acc_next)
    );

    ibid_format u_format (
        .i_st     (acc_next),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load_ok) begin
            r_out_valid <= in_consume && r_in.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load_ok && in_consume && r_in.last) begin
            r_out <= result;
        end
    end

    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hdl/ibid_accum.sv -----
// ----------------------------------------------------------------------------
// ibid_accum: per-octet digit accumulator
// Decodes one octet into up to two digits and folds them into the running
// key, decimal totals and field accumulators. Clears at the final octet.
// ----------------------------------------------------------------------------
module ibid_accum (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  ibid_pkg::t_in_beat    i_beat,
    output ibid_pkg::t_acc_state  o_next
);

    ibid_pkg::t_acc_state r_st;
    ibid_pkg::t_acc_state n_st;

    function automatic ibid_pkg::t_acc_state push_digit(input ibid_pkg::t_acc_state s,
                                                        input logic [3:0] v);
        ibid_pkg::t_acc_state r;
        logic [4:0]           pos;
        r   = s;
        pos = s.digits_seen + 5'd1;
        if (!s.digits_seen[4]) begin
            r.packed_digits = s.packed_digits | (64'(v) << {s.digits_seen[3:0], 2'b00});
        end
        r.decimal_total = (s.decimal_total << 3) + (s.decimal_total << 1) + 54'(v);
        if (v > ibid_pkg::MAX_DIGIT_VALUE) begin
            r.bad_digit = 1'b1;
        end
        if (pos <= 5'd3) begin
            r.country_acc = (s.country_acc << 3) + (s.country_acc << 1) + 10'(v);
            if (pos == 5'd3) begin
                r.three_digit_flag = ibid_pkg::wide_country(r.country_acc);
            end
        end else if (pos <= 5'd5 || (pos == 5'd6 && s.three_digit_flag)) begin
            r.network_acc = (s.network_acc << 3) + (s.network_acc << 1) + 10'(v);
        end else begin
            r.subscriber_acc = (s.subscriber_acc << 3) + (s.subscriber_acc << 1) + 37'(v);
        end
        r.digits_seen = pos;
        return r;
    endfunction

    always_comb begin
        logic [3:0] lo;
        logic [3:0] hi;
        logic       first;
        logic       too_long;
        lo    = i_beat.data_byte[3:0];
        hi    = i_beat.data_byte[7:4];
        first = (r_st.byte_index == 4'd0);
        n_st  = r_st;

        if (first) begin
            n_st.latched_mode = i_beat.mode;
            if (!i_beat.mode) begin
                unique case (lo)
                    ibid_pkg::IMSI_TYPE_EVEN: n_st.odd_flag   = 1'b0;
                    ibid_pkg::IMSI_TYPE_ODD:  n_st.odd_flag   = 1'b1;
                    default:                  n_st.type_error = 1'b1;
                endcase
            end
        end

        // 24.008 even layout carries one extra octet of filler
        if (!n_st.latched_mode && !n_st.odd_flag) begin
            too_long = (r_st.byte_index > 4'(ibid_pkg::MAX_PACKED_BYTES))
                    || (r_st.byte_index == 4'(ibid_pkg::MAX_PACKED_BYTES) && !i_beat.last);
        end else begin
            too_long = (r_st.byte_index >= 4'(ibid_pkg::MAX_PACKED_BYTES));
        end
        if (too_long) begin
            n_st.type_error = 1'b1;
        end

        if (!n_st.type_error) begin
            if (n_st.latched_mode) begin
                n_st = push_digit(n_st, lo);
                if (!(i_beat.last && hi == ibid_pkg::NIBBLE_FILLER)) begin
                    n_st = push_digit(n_st, hi);
                end
            end else begin
                if (!first) begin
                    n_st = push_digit(n_st, lo);
                end
                if (n_st.odd_flag || !i_beat.last) begin
                    n_st = push_digit(n_st, hi);
                end
            end
        end

        // saturate the octet count
        if (r_st.byte_index != 4'd15) begin
            n_st.byte_index = r_st.byte_index + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_advance) begin
            r_st <= i_beat.last ? '0 : n_st;
        end
    end

    assign o_next = n_st;

endmodule

// ----- hdl/ibid_format.sv -----
// ----------------------------------------------------------------------------
// ibid_format: result formatter
// Turns the accumulator state after the final octet into the result beat:
// filler nibble, validity check and zeroing of the split fields.
// ----------------------------------------------------------------------------
module ibid_format (
    input  ibid_pkg::t_acc_state i_st,
    output ibid_pkg::t_result    o_result
);

    always_comb begin
        logic [4:0]  n;
        logic [63:0] key;
        logic        valid;
        n        = i_st.digits_seen;
        key      = i_st.packed_digits;
        valid    = (n >= ibid_pkg::MIN_VALID_DIGITS) && (n <= ibid_pkg::MAX_DIGITS)
                && !i_st.bad_digit;
        o_result = '0;

        // mark an odd count with a filler nibble
        if (n[0] && !n[4]) begin
            key = key | (64'(ibid_pkg::NIBBLE_FILLER) << {n[3:0], 2'b00});
        end

        if (!i_st.type_error) begin
            o_result.ok          = 1'b1;
            o_result.digit_count = n;
            o_result.packed_key  = key;
            o_result.imsi_number = i_st.decimal_total;
            if (valid) begin
                o_result.country_code      = i_st.country_acc;
                o_result.network_code      = i_st.network_acc;
                o_result.wide_network_code = i_st.three_digit_flag;
                o_result.subscriber_number = i_st.subscriber_acc;
                o_result.valid_res         = 1'b1;
            end
        end
    end

endmodule
